### sv/atl_pkg.sv
// ----------------------------------------------------------------------------
// atl_pkg
// Shared widths, limits and the arctangent table for the tilt angle pipeline.
// ----------------------------------------------------------------------------
package atl_pkg;

    // cordic iterations, capped at ATAN_LEN
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int SHW          = 5;

    // square root datapath
    localparam int SQW        = 32;
    localparam int ROOTW      = 32;
    localparam int REMW       = 35;
    localparam int SQRT_STEPS = ROOTW;

    // cordic vector and angle widths, angle lsb is 2^-16 degree
    localparam int VW = 36;
    localparam int AW = 28;
    localparam int OW = 17;

    localparam int PITCH_LIMIT = 23040;
    localparam int ROLL_LIMIT  = 46080;
    localparam int HALF_TURN   = 180 * 65536;

    // round(atan(2^-i) in degrees * 65536)
    function automatic logic signed [AW-1:0] atan_q16(input int idx);
        logic signed [AW-1:0] v;
        case (idx)
            0:       v = AW'(2949120);
            1:       v = AW'(1740967);
            2:       v = AW'(919879);
            3:       v = AW'(466945);
            4:       v = AW'(234379);
            5:       v = AW'(117304);
            6:       v = AW'(58666);
            7:       v = AW'(29335);
            8:       v = AW'(14668);
            9:       v = AW'(7334);
            10:      v = AW'(3667);
            11:      v = AW'(1833);
            12:      v = AW'(917);
            13:      v = AW'(458);
            14:      v = AW'(229);
            15:      v = AW'(115);
            16:      v = AW'(57);
            17:      v = AW'(29);
            18:      v = AW'(14);
            19:      v = AW'(7);
            20:      v = AW'(4);
            21:      v = AW'(2);
            22:      v = AW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/atl_sqrt_stage.sv
// ----------------------------------------------------------------------------
// atl_sqrt_stage
// One digit of a restoring integer square root: one result bit per stage.
// ----------------------------------------------------------------------------
module atl_sqrt_stage
    import atl_pkg::*;
(
    input  logic [REMW-1:0]  rem_in,
    input  logic [ROOTW-1:0] root_in,
    input  logic [SQW-1:0]   sq_in,
    output logic [REMW-1:0]  rem_out,
    output logic [ROOTW-1:0] root_out,
    output logic [SQW-1:0]   sq_out
);

    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;

    // bring down the next two radicand bits and try a one bit
    always_comb
    begin
        rem_sh = {rem_in[REMW-3:0], sq_in[SQW-1:SQW-2]};
        trial  = REMW'({root_in, 2'b01});
        sq_out = {sq_in[SQW-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            rem_out  = rem_sh - trial;
            root_out = {root_in[ROOTW-2:0], 1'b1};
        end
        else
        begin
            rem_out  = rem_sh;
            root_out = {root_in[ROOTW-2:0], 1'b0};
        end
    end

endmodule

### sv/atl_cordic_stage.sv
// ----------------------------------------------------------------------------
// atl_cordic_stage
// One vectoring cordic micro-rotation driving y toward zero.
// ----------------------------------------------------------------------------
module atl_cordic_stage
    import atl_pkg::*;
(
    input  logic signed [VW-1:0] vx_in,
    input  logic signed [VW-1:0] vy_in,
    input  logic signed [AW-1:0] ang_in,
    input  logic [SHW-1:0]       shift,
    input  logic signed [AW-1:0] atan,
    output logic signed [VW-1:0] vx_out,
    output logic signed [VW-1:0] vy_out,
    output logic signed [AW-1:0] ang_out
);

    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic                 vy_neg;
    logic                 vy_zero;

    // rotate against the sign of y, no move when y is zero
    always_comb
    begin
        dx      = vy_in >>> shift;
        dy      = vx_in >>> shift;
        vy_neg  = vy_in[VW-1];
        vy_zero = (vy_in == '0);
        if (vy_zero)
        begin
            vx_out  = vx_in;
            vy_out  = vy_in;
            ang_out = ang_in;
        end
        else if (!vy_neg)
        begin
            vx_out  = vx_in + dx;
            vy_out  = vy_in - dy;
            ang_out = ang_in + atan;
        end
        else
        begin
            vx_out  = vx_in - dx;
            vy_out  = vy_in + dy;
            ang_out = ang_in - atan;
        end
    end

endmodule

### sv/atl_round_sat.sv
// ----------------------------------------------------------------------------
// atl_round_sat
// Rounds a 2^-16 degree angle to 1/256 degree and clamps it to +-limit.
// ----------------------------------------------------------------------------
module atl_round_sat
    import atl_pkg::*;
(
    input  logic signed [AW-1:0] ang,
    input  logic signed [OW-1:0] limit,
    output logic signed [OW-1:0] result
);

    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] lim_w;

    // round half up, then saturate
    always_comb
    begin
        rnd   = (ang + AW'(128)) >>> 8;
        lim_w = AW'(limit);
        if (rnd > lim_w)
        begin
            result = limit;
        end
        else if (rnd < -lim_w)
        begin
            result = -limit;
        end
        else
        begin
            result = OW'(rnd);
        end
    end

endmodule

### sv/accel_tilt_angles.sv
// Registered steps in order: squares, sum, square root digits, pitch cordic, output.
// Throughput: one request per cycle; the whole pipeline holds while the
// output request is stalled.
// Depth is set by the 32 square root digit stages and the cordic stages.
// Reset clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Pitch and roll from one accelerometer sample via square root and cordic.
// ----------------------------------------------------------------------------
module accel_tilt_angles
    import atl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] pitch_deg,
    output logic signed [16:0] roll_deg
);

    logic adv;

    // stage a: squares
    logic               va_reg;
    logic [30:0]        xx_reg;
    logic [30:0]        zz_reg;
    logic signed [15:0] xa_reg;
    logic signed [15:0] ya_reg;
    logic signed [15:0] za_reg;
    logic signed [31:0] xx_w;
    logic signed [31:0] zz_w;

    // stage b: sum and roll setup
    logic                 vb_reg;
    logic [SQW-1:0]       sq_reg;
    logic signed [15:0]   yb_reg;
    logic signed [VW-1:0] rvxb_reg;
    logic signed [VW-1:0] rvyb_reg;
    logic signed [AW-1:0] rangb_reg;
    logic signed [VW-1:0] xs_w;
    logic signed [VW-1:0] zs_w;
    logic signed [VW-1:0] rvx_next;
    logic signed [VW-1:0] rvy_next;
    logic signed [AW-1:0] rang_next;

    // square root stages, roll cordic runs alongside
    logic                 vs_reg   [SQRT_STEPS];
    logic [REMW-1:0]      rem_reg  [SQRT_STEPS];
    logic [ROOTW-1:0]     root_reg [SQRT_STEPS];
    logic [SQW-1:0]       sqs_reg  [SQRT_STEPS];
    logic signed [15:0]   ys_reg   [SQRT_STEPS];
    logic signed [VW-1:0] rvx_reg  [SQRT_STEPS];
    logic signed [VW-1:0] rvy_reg  [SQRT_STEPS];
    logic signed [AW-1:0] rang_reg [SQRT_STEPS];
    logic [REMW-1:0]      rem_in   [SQRT_STEPS];
    logic [ROOTW-1:0]     root_in  [SQRT_STEPS];
    logic [SQW-1:0]       sq_in    [SQRT_STEPS];
    logic signed [15:0]   ys_in    [SQRT_STEPS];
    logic signed [VW-1:0] rvx_in   [SQRT_STEPS];
    logic signed [VW-1:0] rvy_in   [SQRT_STEPS];
    logic signed [AW-1:0] rang_in  [SQRT_STEPS];
    logic                 vs_in    [SQRT_STEPS];
    logic [REMW-1:0]      rem_next [SQRT_STEPS];
    logic [ROOTW-1:0]     root_next[SQRT_STEPS];
    logic [SQW-1:0]       sq_next  [SQRT_STEPS];
    logic signed [VW-1:0] rvxs_next[SQRT_STEPS];
    logic signed [VW-1:0] rvys_next[SQRT_STEPS];
    logic signed [AW-1:0] rangs_next[SQRT_STEPS];

    // pitch cordic stages
    logic                 vc_reg    [CSTEPS];
    logic signed [VW-1:0] pvx_reg   [CSTEPS];
    logic signed [VW-1:0] pvy_reg   [CSTEPS];
    logic signed [AW-1:0] pang_reg  [CSTEPS];
    logic signed [AW-1:0] rangc_reg [CSTEPS];
    logic                 vc_in     [CSTEPS];
    logic signed [VW-1:0] pvx_in    [CSTEPS];
    logic signed [VW-1:0] pvy_in    [CSTEPS];
    logic signed [AW-1:0] pang_in   [CSTEPS];
    logic signed [AW-1:0] rangc_in  [CSTEPS];
    logic signed [VW-1:0] pvx_next  [CSTEPS];
    logic signed [VW-1:0] pvy_next  [CSTEPS];
    logic signed [AW-1:0] pang_next [CSTEPS];

    // output register
    logic                 vo_reg;
    logic signed [OW-1:0] pitch_reg;
    logic signed [OW-1:0] roll_reg;
    logic signed [OW-1:0] pitch_next;
    logic signed [OW-1:0] roll_next;

    // pipeline moves unless the output request is held
    assign adv      = !(vo_reg && out_stall);
    assign in_stall = !adv;

    // stage a
    assign xx_w = accel_x * accel_x;
    assign zz_w = accel_z * accel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xx_reg <= xx_w[30:0];
            zz_reg <= zz_w[30:0];
            xa_reg <= accel_x;
            ya_reg <= accel_y;
            za_reg <= accel_z;
        end
    end

    // stage b: roll vector, turned by a half turn when z is negative
    always_comb
    begin
        xs_w = VW'(xa_reg) <<< 16;
        zs_w = VW'(za_reg) <<< 16;
        if (za_reg[15])
        begin
            rvx_next  = -zs_w;
            rvy_next  = xs_w;
            rang_next = xa_reg[15] ? AW'(HALF_TURN) : -AW'(HALF_TURN);
        end
        else
        begin
            rvx_next  = zs_w;
            rvy_next  = -xs_w;
            rang_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg    <= SQW'(xx_reg) + SQW'(zz_reg);
            yb_reg    <= ya_reg;
            rvxb_reg  <= rvx_next;
            rvyb_reg  <= rvy_next;
            rangb_reg <= rang_next;
        end
    end

    // square root chain
    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            if (k == 0)
            begin : g_first
                assign vs_in[k]   = vb_reg;
                assign rem_in[k]  = '0;
                assign root_in[k] = '0;
                assign sq_in[k]   = sq_reg;
                assign ys_in[k]   = yb_reg;
                assign rvx_in[k]  = rvxb_reg;
                assign rvy_in[k]  = rvyb_reg;
                assign rang_in[k] = rangb_reg;
            end
            else
            begin : g_rest
                assign vs_in[k]   = vs_reg[k-1];
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
                assign sq_in[k]   = sqs_reg[k-1];
                assign ys_in[k]   = ys_reg[k-1];
                assign rvx_in[k]  = rvx_reg[k-1];
                assign rvy_in[k]  = rvy_reg[k-1];
                assign rang_in[k] = rang_reg[k-1];
            end

            atl_sqrt_stage u_sqrt (
                .rem_in   (rem_in[k]),
                .root_in  (root_in[k]),
                .sq_in    (sq_in[k]),
                .rem_out  (rem_next[k]),
                .root_out (root_next[k]),
                .sq_out   (sq_next[k])
            );

            // roll cordic shares the early stages
            if (k < CSTEPS)
            begin : g_roll
                atl_cordic_stage u_roll (
                    .vx_in   (rvx_in[k]),
                    .vy_in   (rvy_in[k]),
                    .ang_in  (rang_in[k]),
                    .shift   (SHW'(k)),
                    .atan    (atan_q16(k)),
                    .vx_out  (rvxs_next[k]),
                    .vy_out  (rvys_next[k]),
                    .ang_out (rangs_next[k])
                );
            end
            else
            begin : g_hold
                assign rvxs_next[k]  = rvx_in[k];
                assign rvys_next[k]  = rvy_in[k];
                assign rangs_next[k] = rang_in[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vs_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    vs_reg[k] <= vs_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= rem_next[k];
                    root_reg[k] <= root_next[k];
                    sqs_reg[k]  <= sq_next[k];
                    ys_reg[k]   <= ys_in[k];
                    rvx_reg[k]  <= rvxs_next[k];
                    rvy_reg[k]  <= rvys_next[k];
                    rang_reg[k] <= rangs_next[k];
                end
            end
        end
    endgenerate

    // pitch cordic chain
    genvar c;
    generate
        for (c = 0; c < CSTEPS; c++)
        begin : g_pitch
            if (c == 0)
            begin : g_first
                assign vc_in[c]    = vs_reg[SQRT_STEPS-1];
                assign pvx_in[c]   = VW'(root_reg[SQRT_STEPS-1]);
                assign pvy_in[c]   = VW'(ys_reg[SQRT_STEPS-1]) <<< 16;
                assign pang_in[c]  = '0;
                assign rangc_in[c] = rang_reg[SQRT_STEPS-1];
            end
            else
            begin : g_rest
                assign vc_in[c]    = vc_reg[c-1];
                assign pvx_in[c]   = pvx_reg[c-1];
                assign pvy_in[c]   = pvy_reg[c-1];
                assign pang_in[c]  = pang_reg[c-1];
                assign rangc_in[c] = rangc_reg[c-1];
            end

            atl_cordic_stage u_pitch (
                .vx_in   (pvx_in[c]),
                .vy_in   (pvy_in[c]),
                .ang_in  (pang_in[c]),
                .shift   (SHW'(c)),
                .atan    (atan_q16(c)),
                .vx_out  (pvx_next[c]),
                .vy_out  (pvy_next[c]),
                .ang_out (pang_next[c])
            );

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vc_reg[c] <= 1'b0;
                end
                else if (adv)
                begin
                    vc_reg[c] <= vc_in[c];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pvx_reg[c]   <= pvx_next[c];
                    pvy_reg[c]   <= pvy_next[c];
                    pang_reg[c]  <= pang_next[c];
                    rangc_reg[c] <= rangc_in[c];
                end
            end
        end
    endgenerate

    // rounding and saturation
    atl_round_sat u_pitch_rs (
        .ang    (pang_reg[CSTEPS-1]),
        .limit  (OW'(PITCH_LIMIT)),
        .result (pitch_next)
    );

    atl_round_sat u_roll_rs (
        .ang    (rangc_reg[CSTEPS-1]),
        .limit  (OW'(ROLL_LIMIT)),
        .result (roll_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vo_reg <= vc_reg[CSTEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
        end
    end

    assign out_valid = vo_reg;
    assign pitch_deg = pitch_reg[15:0];
    assign roll_deg  = roll_reg;

`ifndef SYNTHESIS
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_reg >= -OW'(PITCH_LIMIT)) && (pitch_reg <= OW'(PITCH_LIMIT)))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_deg >= -OW'(ROLL_LIMIT)) && (roll_deg <= OW'(ROLL_LIMIT)))
        else $error("roll out of range");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vc_reg[CSTEPS-1]) && $stable(vb_reg))
        else $error("pipeline moved while output held");
`endif

endmodule
